>>> hw/rtl/tcti_pkg.sv
package tcti_pkg;

  localparam int COV_WIDTH_DEF = 64;
  localparam int Z_WIDTH_DEF   = 32;
  localparam int NELEM         = 15;
  localparam int ELEM_W        = 4;
  localparam int FRAC_W        = 32;
  localparam int CFG_IDX_W     = 1;
  localparam int QUEUE_DEPTH   = 2;
  localparam int Z_END_RESET   = 65536;

  localparam logic [1:0] MODE_LOAD_BEGIN = 2'd0;
  localparam logic [1:0] MODE_LOAD_END   = 2'd1;
  localparam logic [1:0] MODE_QUERY      = 2'd2;
  localparam logic [1:0] MODE_RESERVED   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_Z_BEGIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_END   = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD_BEGIN,
    CMD_LOAD_END,
    CMD_QUERY
  } cmd_kind_t;

  typedef enum logic [1:0] {
    REGION_BEGIN,
    REGION_END,
    REGION_BLEND
  } region_t;

  typedef struct packed {
    cmd_kind_t         kind;
    region_t           region;
    logic [ELEM_W-1:0] sel;
  } cmd_ctl_t;

  // Operands of one transported element: C' = C + dz*(dz*Cx + (Cya + Cyb)).
  typedef struct packed {
    logic              has_x;
    logic [ELEM_W-1:0] x_idx;
    logic              has_ya;
    logic [ELEM_W-1:0] ya_idx;
    logic              has_yb;
    logic [ELEM_W-1:0] yb_idx;
  } elem_taps_t;

  function automatic elem_taps_t elem_taps(input logic [ELEM_W-1:0] e);
    elem_taps_t t;
    t = '0;
    case (e)
      4'd0: begin
        t.has_x = 1'b1; t.x_idx = 4'd5;
        t.has_ya = 1'b1; t.ya_idx = 4'd3; t.has_yb = 1'b1; t.yb_idx = 4'd3;
      end
      4'd1: begin
        t.has_x = 1'b1; t.x_idx = 4'd8;
        t.has_ya = 1'b1; t.ya_idx = 4'd6; t.has_yb = 1'b1; t.yb_idx = 4'd4;
      end
      4'd2: begin
        t.has_x = 1'b1; t.x_idx = 4'd9;
        t.has_ya = 1'b1; t.ya_idx = 4'd7; t.has_yb = 1'b1; t.yb_idx = 4'd7;
      end
      4'd3: begin
        t.has_ya = 1'b1; t.ya_idx = 4'd5;
      end
      4'd4: begin
        t.has_ya = 1'b1; t.ya_idx = 4'd8;
      end
      4'd6: begin
        t.has_ya = 1'b1; t.ya_idx = 4'd8;
      end
      4'd7: begin
        t.has_ya = 1'b1; t.ya_idx = 4'd9;
      end
      4'd10: begin
        t.has_ya = 1'b1; t.ya_idx = 4'd12;
      end
      4'd11: begin
        t.has_ya = 1'b1; t.ya_idx = 4'd13;
      end
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

>>> hw/rtl/track_covariance_transport_interp.sv
// Straight-line transport and interpolation of a 5x5 track covariance.
// Requests arrive on item_valid/item_stall: mode 0 and 1 load one
// lower-triangle element of the begin or end matrix, mode 2 queries the
// covariance at query_z. Each query returns 15 elements on
// result_valid/result_stall in index order, last set on element 14.
// z_begin and z_end are written through cfg_valid/cfg_ready (index 0, 1);
// the user must write them only while the block is idle; the block does
// not enforce this. cfg_ready is always high. A front stage classifies
// requests and computes the blend weight with a restoring divider; a
// two-entry queue feeds the back stage. The back stage uses one
// shift-and-add multiplier, M = max(Z_WIDTH+1, 34) bits, one multiplier bit
// per cycle. A query outside the interval transports one matrix; one inside
// it transports both matrices and blends the results.
// Reset clears all control state and sets z_begin to 0, z_end to 1.0;
// matrix elements hold no value until loaded.
// When result_stall is high the result register holds and the back stage
// waits; the front takes requests unless dividing or the queue is full.
module track_covariance_transport_interp #(
  parameter int COV_WIDTH = tcti_pkg::COV_WIDTH_DEF,
  parameter int Z_WIDTH   = tcti_pkg::Z_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic [1:0]                     mode,
  input  logic [tcti_pkg::ELEM_W-1:0]    elem_select,
  input  logic signed [COV_WIDTH-1:0]    load_value,
  input  logic signed [Z_WIDTH-1:0]      query_z,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tcti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic signed [Z_WIDTH-1:0]      cfg_data,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [tcti_pkg::ELEM_W-1:0]    elem_index,
  output logic signed [COV_WIDTH-1:0]    cov_value,
  output logic                           last,
  output logic                           saturated
);
  import tcti_pkg::*;

  localparam int DZ_W  = Z_WIDTH + 1;
  localparam int CTL_W = $bits(cmd_ctl_t);
  localparam int QW    = CTL_W + COV_WIDTH + 2 * DZ_W + FRAC_W;

  logic                   q_push;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_valid;
  cmd_ctl_t               f_ctl;
  logic [COV_WIDTH-1:0]   f_value;
  logic signed [DZ_W-1:0] f_dz_begin;
  logic signed [DZ_W-1:0] f_dz_end;
  logic [FRAC_W-1:0]      f_frac;
  logic [QW-1:0]          q_wdata;
  logic [QW-1:0]          q_rdata;
  cmd_ctl_t               b_ctl;
  logic [COV_WIDTH-1:0]   b_value;
  logic signed [DZ_W-1:0] b_dz_begin;
  logic signed [DZ_W-1:0] b_dz_end;
  logic [FRAC_W-1:0]      b_frac;

  tcti_front #(.COV_WIDTH(COV_WIDTH), .Z_WIDTH(Z_WIDTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .mode        (mode),
    .elem_select (elem_select),
    .load_value  (load_value),
    .query_z     (query_z),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_ctl       (f_ctl),
    .q_value     (f_value),
    .q_dz_begin  (f_dz_begin),
    .q_dz_end    (f_dz_end),
    .q_frac      (f_frac)
  );

  assign q_wdata = {f_ctl, f_value, f_dz_begin, f_dz_end, f_frac};

  tcti_queue #(.WIDTH(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  assign b_ctl      = cmd_ctl_t'(q_rdata[QW-1 -: CTL_W]);
  assign b_value    = q_rdata[QW-CTL_W-1 -: COV_WIDTH];
  assign b_dz_begin = q_rdata[FRAC_W+2*DZ_W-1 -: DZ_W];
  assign b_dz_end   = q_rdata[FRAC_W+DZ_W-1 -: DZ_W];
  assign b_frac     = q_rdata[FRAC_W-1:0];

  tcti_back #(.COV_WIDTH(COV_WIDTH), .Z_WIDTH(Z_WIDTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_ctl        (b_ctl),
    .q_value      (b_value),
    .q_dz_begin   (b_dz_begin),
    .q_dz_end     (b_dz_end),
    .q_frac       (b_frac),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .elem_index   (elem_index),
    .cov_value    (cov_value),
    .last         (last),
    .saturated    (saturated)
  );

`ifndef SYNTHESIS
  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> elem_index == ELEM_W'(NELEM - 1))
    else $error("last flag set on an element other than the final one");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("front pushed into a full queue");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");
`endif

endmodule

>>> hw/rtl/tcti_ram.sv
module tcti_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/tcti_queue.sv
module tcti_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);
  import tcti_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign rdata   = slot[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/tcti_front.sv
module tcti_front #(
  parameter int COV_WIDTH = tcti_pkg::COV_WIDTH_DEF,
  parameter int Z_WIDTH   = tcti_pkg::Z_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [1:0]                      mode,
  input  logic [tcti_pkg::ELEM_W-1:0]     elem_select,
  input  logic signed [COV_WIDTH-1:0]     load_value,
  input  logic signed [Z_WIDTH-1:0]       query_z,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tcti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic signed [Z_WIDTH-1:0]       cfg_data,
  input  logic                            q_full,
  output logic                            q_push,
  output tcti_pkg::cmd_ctl_t              q_ctl,
  output logic [COV_WIDTH-1:0]            q_value,
  output logic signed [Z_WIDTH:0]         q_dz_begin,
  output logic signed [Z_WIDTH:0]         q_dz_end,
  output logic [tcti_pkg::FRAC_W-1:0]     q_frac
);
  import tcti_pkg::*;

  localparam int DZ_W  = Z_WIDTH + 1;
  localparam int CNT_W = $clog2(FRAC_W);

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } fstate_t;

  fstate_t                  state;
  logic signed [Z_WIDTH-1:0] z_begin;
  logic signed [Z_WIDTH-1:0] z_end;
  logic signed [DZ_W-1:0]   zq;
  logic signed [DZ_W-1:0]   zb;
  logic signed [DZ_W-1:0]   ze;
  logic signed [DZ_W-1:0]   dz_b_now;
  logic signed [DZ_W-1:0]   dz_e_now;
  logic signed [DZ_W-1:0]   den_now;
  logic signed [DZ_W-1:0]   dz_b_hold;
  logic signed [DZ_W-1:0]   dz_e_hold;
  region_t                  region_now;
  cmd_ctl_t                 ctl_now;
  logic                     accept;
  logic                     direct;
  logic                     start_div;
  logic [DZ_W-1:0]          rem;
  logic [DZ_W-1:0]          den;
  logic [DZ_W:0]            rem2;
  logic [FRAC_W-1:0]        frac;
  logic [CNT_W-1:0]         cnt;

  assign cfg_ready = 1'b1;

  assign zq       = DZ_W'(query_z);
  assign zb       = DZ_W'(z_begin);
  assign ze       = DZ_W'(z_end);
  assign dz_b_now = zq - zb;
  assign dz_e_now = zq - ze;
  assign den_now  = ze - zb;

  // The test against z_begin wins when the interval is empty or reversed.
  always_comb begin
    if (!(zb < zq)) begin
      region_now = REGION_BEGIN;
    end else if (!(zq < ze)) begin
      region_now = REGION_END;
    end else begin
      region_now = REGION_BLEND;
    end
  end

  always_comb begin
    ctl_now.sel    = elem_select;
    ctl_now.region = region_now;
    ctl_now.kind   = CMD_QUERY;
    direct         = 1'b0;
    case (mode)
      MODE_LOAD_BEGIN: begin
        ctl_now.kind = CMD_LOAD_BEGIN;
        direct       = (elem_select < ELEM_W'(NELEM));
      end
      MODE_LOAD_END: begin
        ctl_now.kind = CMD_LOAD_END;
        direct       = (elem_select < ELEM_W'(NELEM));
      end
      MODE_QUERY: begin
        ctl_now.kind = CMD_QUERY;
        direct       = (region_now != REGION_BLEND);
      end
      default: direct = 1'b0;
    endcase
  end

  assign item_stall = (state != F_IDLE) || q_full;
  assign accept     = item_valid && !item_stall;
  assign start_div  = accept && (mode == MODE_QUERY) && (region_now == REGION_BLEND);

  assign q_push     = (state == F_IDLE && accept && direct) || (state == F_PUSH && !q_full);
  assign q_ctl      = (state == F_PUSH) ?
                      cmd_ctl_t'{kind: CMD_QUERY, region: REGION_BLEND, sel: '0} : ctl_now;
  assign q_value    = load_value;
  assign q_dz_begin = (state == F_PUSH) ? dz_b_hold : dz_b_now;
  assign q_dz_end   = (state == F_PUSH) ? dz_e_hold : dz_e_now;
  assign q_frac     = frac;

  assign rem2 = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      z_begin <= '0;
      z_end   <= Z_WIDTH'(Z_END_RESET);
      cnt     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_Z_BEGIN: z_begin <= cfg_data;
          CFG_Z_END:   z_end   <= cfg_data;
          default:     z_begin <= z_begin;
        endcase
      end
      case (state)
        F_IDLE: begin
          if (start_div) begin
            rem       <= dz_b_now;
            den       <= den_now;
            dz_b_hold <= dz_b_now;
            dz_e_hold <= dz_e_now;
            frac      <= '0;
            cnt       <= '0;
            state     <= F_DIV;
          end
        end
        F_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (rem2 >= {1'b0, den}) begin
            rem  <= DZ_W'(rem2 - {1'b0, den});
            frac <= {frac[FRAC_W-2:0], 1'b1};
          end else begin
            rem  <= rem2[DZ_W-1:0];
            frac <= {frac[FRAC_W-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(FRAC_W - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/tcti_back.sv
module tcti_back #(
  parameter int COV_WIDTH = tcti_pkg::COV_WIDTH_DEF,
  parameter int Z_WIDTH   = tcti_pkg::Z_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  tcti_pkg::cmd_ctl_t          q_ctl,
  input  logic [COV_WIDTH-1:0]        q_value,
  input  logic signed [Z_WIDTH:0]     q_dz_begin,
  input  logic signed [Z_WIDTH:0]     q_dz_end,
  input  logic [tcti_pkg::FRAC_W-1:0] q_frac,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [tcti_pkg::ELEM_W-1:0] elem_index,
  output logic signed [COV_WIDTH-1:0] cov_value,
  output logic                        last,
  output logic                        saturated
);
  import tcti_pkg::*;

  localparam int DZ_W = Z_WIDTH + 1;
  localparam int M_W  = (DZ_W > FRAC_W + 2) ? DZ_W : FRAC_W + 2;
  localparam int IN_W = COV_WIDTH + DZ_W + 1;
  localparam int T_W  = IN_W + DZ_W;
  localparam int BL_W = T_W + 35;
  localparam int R_W  = BL_W - 32;
  localparam int MC_W = $clog2(M_W);
  localparam logic [BL_W-1:0] HALF32 = BL_W'(1) << 31;
  localparam logic [BL_W-1:0] HALF64 = BL_W'(1) << 63;
  localparam logic [COV_WIDTH-1:0] COV_MAX = {1'b0, {(COV_WIDTH - 1){1'b1}}};
  localparam logic [COV_WIDTH-1:0] COV_MIN = {1'b1, {(COV_WIDTH - 1){1'b0}}};

  typedef enum logic [3:0] {
    B_IDLE,
    B_RX,
    B_RYA,
    B_RYB,
    B_RC,
    B_M1S,
    B_M1,
    B_M2S,
    B_M2,
    B_B1S,
    B_B1,
    B_B2S,
    B_B2,
    B_OUT
  } bstate_t;

  bstate_t                  state;
  region_t                  region;
  logic [ELEM_W-1:0]        elem;
  logic                     mat;
  logic signed [DZ_W-1:0]   dz_b;
  logic signed [DZ_W-1:0]   dz_e;
  logic signed [DZ_W-1:0]   dz_cur;
  logic [FRAC_W-1:0]        frac;
  logic [FRAC_W:0]          wa;
  logic signed [COV_WIDTH-1:0] cx;
  logic signed [COV_WIDTH-1:0] cya;
  logic signed [COV_WIDTH-1:0] cyb;
  logic signed [COV_WIDTH-1:0] cc;
  logic signed [COV_WIDTH:0]   cy_sum;
  logic signed [T_W-1:0]    ta;
  logic signed [T_W-1:0]    tb;
  logic signed [BL_W-1:0]   acc;
  logic signed [BL_W-1:0]   mx;
  logic signed [BL_W-1:0]   addend;
  logic signed [BL_W-1:0]   acc_mac;
  logic signed [M_W-1:0]    mm;
  logic [MC_W-1:0]          mcnt;
  logic                     mac_last;
  elem_taps_t               taps;
  logic [ELEM_W-1:0]        raddr;
  logic [COV_WIDTH-1:0]     bm_rdata;
  logic [COV_WIDTH-1:0]     em_rdata;
  logic [COV_WIDTH-1:0]     rdata_sel;
  logic                     bm_we;
  logic                     em_we;
  logic [BL_W-1:0]          sum32;
  logic [BL_W-1:0]          sum64;
  logic signed [BL_W-65:0]  q64;
  logic signed [R_W-1:0]    rr;
  logic [R_W-COV_WIDTH:0]   top_bits;
  logic                     ovf;
  logic                     out_free;

  assign q_pop = (state == B_IDLE) && q_valid;
  assign bm_we = q_pop && (q_ctl.kind == CMD_LOAD_BEGIN);
  assign em_we = q_pop && (q_ctl.kind == CMD_LOAD_END);

  tcti_ram #(.WIDTH(COV_WIDTH), .DEPTH(NELEM)) u_begin_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (q_ctl.sel),
    .wdata (q_value),
    .raddr (raddr),
    .rdata (bm_rdata)
  );

  tcti_ram #(.WIDTH(COV_WIDTH), .DEPTH(NELEM)) u_end_ram (
    .clk   (clk),
    .we    (em_we),
    .waddr (q_ctl.sel),
    .wdata (q_value),
    .raddr (raddr),
    .rdata (em_rdata)
  );

  assign taps      = elem_taps(elem);
  assign rdata_sel = mat ? em_rdata : bm_rdata;
  assign dz_cur    = mat ? dz_e : dz_b;
  assign wa        = {1'b1, {FRAC_W{1'b0}}} - {1'b0, frac};
  assign cy_sum    = (COV_WIDTH + 1)'(cya) + (COV_WIDTH + 1)'(cyb);

  always_comb begin
    case (state)
      B_RX:    raddr = taps.x_idx;
      B_RYA:   raddr = taps.ya_idx;
      B_RYB:   raddr = taps.yb_idx;
      default: raddr = elem;
    endcase
  end

  // Shift-and-add multiplier, one multiplier bit per cycle; the top bit
  // carries negative weight.
  assign mac_last = (mcnt == MC_W'(M_W - 1));
  assign addend   = mm[0] ? mx : '0;
  assign acc_mac  = mac_last ? acc - addend : acc + addend;

  // Round to nearest from Q.32 (Q.64 when blending), then clip to the element width.
  assign sum32    = acc + HALF32;
  assign sum64    = acc + HALF64;
  assign q64      = sum64[BL_W-1:64];
  assign rr       = (region == REGION_BLEND) ? R_W'(q64) : sum32[BL_W-1:32];
  assign top_bits = rr[R_W-1:COV_WIDTH-1];
  assign ovf      = !(&top_bits) && (|top_bits);
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      result_valid <= 1'b0;
      elem         <= '0;
      mat          <= 1'b0;
      mcnt         <= '0;
    end else begin
      if (result_valid && !result_stall && state != B_OUT) begin
        result_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_valid && q_ctl.kind == CMD_QUERY) begin
            region <= q_ctl.region;
            dz_b   <= q_dz_begin;
            dz_e   <= q_dz_end;
            frac   <= q_frac;
            elem   <= '0;
            mat    <= (q_ctl.region == REGION_END);
            state  <= B_RX;
          end
        end
        B_RX: state <= B_RYA;
        B_RYA: begin
          cx    <= taps.has_x ? rdata_sel : '0;
          state <= B_RYB;
        end
        B_RYB: begin
          cya   <= taps.has_ya ? rdata_sel : '0;
          state <= B_RC;
        end
        B_RC: begin
          cyb   <= taps.has_yb ? rdata_sel : '0;
          state <= B_M1S;
        end
        B_M1S: begin
          cc    <= rdata_sel;
          acc   <= BL_W'(cy_sum) <<< 16;
          mx    <= BL_W'(cx);
          mm    <= M_W'(dz_cur);
          mcnt  <= '0;
          state <= B_M1;
        end
        B_M1: begin
          acc  <= acc_mac;
          mx   <= mx <<< 1;
          mm   <= mm >>> 1;
          mcnt <= mcnt + 1'b1;
          if (mac_last) begin
            state <= B_M2S;
          end
        end
        B_M2S: begin
          mx    <= acc;
          acc   <= BL_W'(cc) <<< 32;
          mm    <= M_W'(dz_cur);
          mcnt  <= '0;
          state <= B_M2;
        end
        B_M2: begin
          acc  <= acc_mac;
          mx   <= mx <<< 1;
          mm   <= mm >>> 1;
          mcnt <= mcnt + 1'b1;
          if (mac_last) begin
            if (region != REGION_BLEND) begin
              state <= B_OUT;
            end else if (!mat) begin
              ta    <= acc_mac[T_W-1:0];
              mat   <= 1'b1;
              state <= B_RX;
            end else begin
              tb    <= acc_mac[T_W-1:0];
              state <= B_B1S;
            end
          end
        end
        B_B1S: begin
          mx    <= BL_W'(ta);
          acc   <= '0;
          mm    <= M_W'(wa);
          mcnt  <= '0;
          state <= B_B1;
        end
        B_B1: begin
          acc  <= acc_mac;
          mx   <= mx <<< 1;
          mm   <= mm >>> 1;
          mcnt <= mcnt + 1'b1;
          if (mac_last) begin
            state <= B_B2S;
          end
        end
        B_B2S: begin
          mx    <= BL_W'(tb);
          mm    <= M_W'(frac);
          mcnt  <= '0;
          state <= B_B2;
        end
        B_B2: begin
          acc  <= acc_mac;
          mx   <= mx <<< 1;
          mm   <= mm >>> 1;
          mcnt <= mcnt + 1'b1;
          if (mac_last) begin
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            elem_index   <= elem;
            cov_value    <= ovf ? (rr[R_W-1] ? COV_MIN : COV_MAX) : rr[COV_WIDTH-1:0];
            saturated    <= ovf;
            last         <= (elem == ELEM_W'(NELEM - 1));
            if (elem == ELEM_W'(NELEM - 1)) begin
              state <= B_IDLE;
            end else begin
              elem  <= elem + 1'b1;
              mat   <= (region == REGION_END);
              state <= B_RX;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

>>> bench/tb_track_covariance_transport_interp.sv
`timescale 1ns / 1ps

module tb_track_covariance_transport_interp;
  import tcti_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [3:0]  idx;
    logic [63:0] val;
    logic        last;
    logic        sat;
  } cov_elem_t;

  typedef struct {
    logic [1:0]  mode;
    logic [3:0]  sel;
    logic [63:0] val;
    logic [31:0] z;
    bit          known;
    logic [63:0] first_val;
    logic        first_sat;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [1:0] mode = MODE_LOAD_BEGIN;
  logic [ELEM_W-1:0] elem_select = '0;
  logic signed [63:0] load_value = '0;
  logic signed [31:0] query_z = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_Z_BEGIN;
  logic signed [31:0] cfg_data = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [ELEM_W-1:0] elem_index;
  logic signed [63:0] cov_value;
  logic last;
  logic saturated;

  track_covariance_transport_interp dut (.*);

  always #6 clk = ~clk;

  logic [63:0] begin_cov [NELEM];
  logic [63:0] end_cov [NELEM];
  logic signed [31:0] zb_model = 32'sd0;
  logic signed [31:0] ze_model = Z_END_RESET;
  cov_elem_t cov_expected [$];
  stim_row_t typed_first [$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  int stall_left = 0;
  bit cur_known = 1'b0;
  logic [63:0] cur_first_val = '0;
  logic cur_first_sat = 1'b0;

  // C' = F C F^T with the straight-line jacobian, kept at Q.32.
  function automatic void transport(input logic [63:0] m [NELEM], input wide_t dz,
                                    output wide_t t [NELEM]);
    wide_t c [NELEM];
    wide_t dz2;
    dz2 = dz * dz;
    for (int i = 0; i < NELEM; i++) begin
      c[i] = $signed(m[i]);
      t[i] = c[i] <<< 32;
    end
    t[0] = t[0] + dz2 * c[5] + ((dz * (c[3] + c[3])) <<< 16);
    t[1] = t[1] + dz2 * c[8] + ((dz * (c[6] + c[4])) <<< 16);
    t[2] = t[2] + dz2 * c[9] + ((dz * (c[7] + c[7])) <<< 16);
    t[3] = t[3] + ((dz * c[5]) <<< 16);
    t[4] = t[4] + ((dz * c[8]) <<< 16);
    t[6] = t[6] + ((dz * c[8]) <<< 16);
    t[7] = t[7] + ((dz * c[9]) <<< 16);
    t[10] = t[10] + ((dz * c[12]) <<< 16);
    t[11] = t[11] + ((dz * c[13]) <<< 16);
  endfunction

  task automatic predict_query(input logic signed [31:0] zq);
    wide_t z, zb, ze, f, wa, r, hi, lo;
    wide_t ta [NELEM];
    wide_t tb [NELEM];
    cov_elem_t e;
    z = zq;
    zb = zb_model;
    ze = ze_model;
    f = 0;
    if (z <= zb) transport(begin_cov, z - zb, ta);
    else if (z >= ze) transport(end_cov, z - ze, ta);
    else begin
      f = ((z - zb) <<< 32) / (ze - zb);
      transport(begin_cov, z - zb, ta);
      transport(end_cov, z - ze, tb);
    end
    wa = (wide_t'(1) <<< 32) - f;
    hi = wide_t'(1) <<< 63;
    lo = -hi;
    for (int i = 0; i < NELEM; i++) begin
      if (z <= zb || z >= ze) r = (ta[i] + (wide_t'(1) <<< 31)) >>> 32;
      else r = (ta[i] * wa + tb[i] * f + (wide_t'(1) <<< 63)) >>> 64;
      e.sat = 1'b1;
      if (r < lo) r = lo;
      else if (r >= hi) r = hi - 1;
      else e.sat = 1'b0;
      e.idx = i[3:0];
      e.val = r[63:0];
      e.last = (i == NELEM - 1);
      cov_expected.push_back(e);
    end
  endtask

  task automatic report(input string what, input logic [63:0] exp_v, input logic [63:0] act_v);
    errors++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    cov_elem_t e;
    stim_row_t k;
    if (!rst) begin
      if ((item_valid && !item_stall) || (cfg_valid && cfg_ready) ||
          (result_valid && !result_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        if (cfg_valid && cfg_ready) begin
          if (cfg_index == CFG_Z_BEGIN) zb_model = cfg_data;
          else zb_model = zb_model;
          if (cfg_index == CFG_Z_END) ze_model = cfg_data;
        end
        if (item_valid && !item_stall) begin
          if (mode == MODE_LOAD_BEGIN && elem_select < NELEM) begin_cov[elem_select] = load_value;
          else if (mode == MODE_LOAD_END && elem_select < NELEM) end_cov[elem_select] = load_value;
          else if (mode == MODE_QUERY) begin
            predict_query(query_z);
            k.known = cur_known;
            k.first_val = cur_first_val;
            k.first_sat = cur_first_sat;
            typed_first.push_back(k);
          end
        end
        if (result_valid && !result_stall) begin
          if (cov_expected.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, index %0d value %h", $time, elem_index, cov_value);
          end else begin
            e = cov_expected.pop_front();
            if (elem_index !== e.idx) report("elem_index", 64'(e.idx), 64'(elem_index));
            if (cov_value !== e.val) report("cov_value", e.val, cov_value);
            if (last !== e.last) report("last", 64'(e.last), 64'(last));
            if (saturated !== e.sat) report("saturated", 64'(e.sat), 64'(saturated));
            if (e.idx == 0 && typed_first.size() > 0) begin
              k = typed_first.pop_front();
              if (k.known && cov_value !== k.first_val)
                report("typed cov_value", k.first_val, cov_value);
              if (k.known && saturated !== k.first_sat)
                report("typed saturated", 64'(k.first_sat), 64'(saturated));
            end
          end
        end
      end
    end
  end

  // Result stalls come in bursts; no new burst starts once the run is in its quiet part.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      result_stall = 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 12);
      result_stall = 1'b1;
    end else begin
      result_stall = 1'b0;
    end
  end

  task automatic send_request(input logic [1:0] m, input logic [3:0] s, input logic [63:0] v,
                              input logic [31:0] z);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      item_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    mode = m;
    elem_select = s;
    load_value = v;
    query_z = z;
    item_valid = 1'b1;
    do @(posedge clk); while (!(item_valid && !item_stall));
    @(negedge clk);
    item_valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (cov_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [63:0] rand_cov();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return v;
      1: return {{24{v[39]}}, v[39:0]};
      default: return {{34{v[29]}}, v[29:0]};
    endcase
  endfunction

  function automatic logic [31:0] rand_z(input logic signed [31:0] lo_z,
                                         input logic signed [31:0] hi_z);
    logic signed [63:0] span;
    span = hi_z - lo_z;
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return lo_z;
      2: return hi_z;
      default: begin
        if (span <= 0) return lo_z + $signed({1'b0, $urandom_range(0, 20)}) - 10;
        return lo_z + (({32'd0, $urandom} * span) >> 32);
      end
    endcase
  endfunction

  stim_row_t directed [] = '{
    '{MODE_LOAD_BEGIN, 4'd0, 64'h0000_0123_4567_89AB, 32'd0, 0, 64'd0, 1'b0},
    '{MODE_QUERY, 4'd0, 64'd0, 32'd0, 1, 64'h0000_0123_4567_89AB, 1'b0},
    '{MODE_LOAD_BEGIN, 4'd5, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0, 0, 64'd0, 1'b0},
    '{MODE_LOAD_BEGIN, 4'd3, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0, 0, 64'd0, 1'b0},
    '{MODE_QUERY, 4'd0, 64'd0, 32'h8000_0000, 1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1},
    '{MODE_LOAD_BEGIN, 4'd5, 64'h8000_0000_0000_0000, 32'd0, 0, 64'd0, 1'b0},
    '{MODE_QUERY, 4'd0, 64'd0, 32'h8000_0000, 1, 64'h8000_0000_0000_0000, 1'b1},
    '{MODE_QUERY, 4'd0, 64'd0, 32'h7FFF_FFFF, 0, 64'd0, 1'b0},
    '{MODE_QUERY, 4'd0, 64'd0, 32'h0000_8000, 0, 64'd0, 1'b0},
    '{MODE_RESERVED, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 0, 64'd0, 1'b0},
    '{MODE_LOAD_BEGIN, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 0, 64'd0, 1'b0},
    '{MODE_LOAD_END, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 0, 64'd0, 1'b0},
    '{MODE_QUERY, 4'd0, 64'd0, 32'd0, 1, 64'h0000_0123_4567_89AB, 1'b0},
    '{MODE_LOAD_END, 4'd14, 64'h8000_0000_0000_0000, 32'd0, 0, 64'd0, 1'b0},
    '{MODE_LOAD_END, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 0, 64'd0, 1'b0},
    '{MODE_QUERY, 4'd0, 64'd0, 32'h0001_0000, 1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
    '{MODE_QUERY, 4'd0, 64'd0, 32'h0000_0001, 0, 64'd0, 1'b0},
    '{MODE_QUERY, 4'd0, 64'd0, 32'h0000_FFFF, 0, 64'd0, 1'b0},
    '{MODE_LOAD_BEGIN, 4'd0, 64'd0, 32'd0, 0, 64'd0, 1'b0},
    '{MODE_QUERY, 4'd0, 64'd0, 32'd0, 1, 64'd0, 1'b0}
  };

  initial begin
    logic signed [31:0] zb_set [5];
    logic signed [31:0] ze_set [5];
    int pick;
    zb_set = '{32'sh8000_0000, 32'sd65536, 32'sd300000, -32'sd40000, 32'sd0};
    ze_set = '{32'sh7FFF_FFFF, 32'sd65536, 32'sd100000, 32'sd90000, 32'sd655360};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Every element gets a value before the first query reads it.
    for (int i = 0; i < NELEM; i++) begin
      send_request(MODE_LOAD_BEGIN, i[3:0], rand_cov(), 32'd0);
      send_request(MODE_LOAD_END, i[3:0], rand_cov(), 32'd0);
    end
    foreach (directed[r]) begin
      cur_known = directed[r].known;
      cur_first_val = directed[r].first_val;
      cur_first_sat = directed[r].first_sat;
      send_request(directed[r].mode, directed[r].sel, directed[r].val, directed[r].z);
    end
    cur_known = 1'b0;

    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      write_reg(CFG_Z_BEGIN, zb_set[ph]);
      write_reg(CFG_Z_END, ze_set[ph]);
      quiet = (ph == 4);
      for (int n = 0; n < 62; n++) begin
        pick = $urandom_range(0, 19);
        if (pick < 13)
          send_request(pick[0] ? MODE_LOAD_END : MODE_LOAD_BEGIN, 4'($urandom_range(0, 14)),
                       rand_cov(), $urandom);
        else if (pick < 18)
          send_request(MODE_QUERY, 4'($urandom), {$urandom, $urandom},
                       rand_z(zb_set[ph], ze_set[ph]));
        else
          send_request(pick[0] ? MODE_RESERVED : MODE_LOAD_BEGIN, 4'd15,
                       {$urandom, $urandom}, $urandom);
        // Hold the sender off once until the block has emptied.
        if (ph == 1 && n == 30) wait_drained();
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
